// File: rtl/output_fault_isolation_sequencer_defines.svh
// Assertion macros shared by the output fault isolation sequencer RTL.
// Expects a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef OUTPUT_FAULT_ISOLATION_SEQUENCER_DEFINES_SVH
`define OUTPUT_FAULT_ISOLATION_SEQUENCER_DEFINES_SVH

// check outside reset
`define OFIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check on every edge, reset included
`define OFIS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/ofis_pkg.sv
// Package for the output fault isolation sequencer: widths, codes and item/result types.
// No dependencies.
package ofis_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int ADDR_W           = 3;
  localparam int DATA_W           = 32;
  localparam int IN_W             = 8;
  localparam int OUT_W            = 32;
  localparam int DELAY_W          = 13;
  localparam int RETRY_W          = 4;
  localparam int WAIT_W           = 16;
  localparam int LONG_W           = DELAY_W + 4;
  localparam int LONG_FACTOR      = 10;

  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(100);
  localparam logic [RETRY_W-1:0] RETRY_RESET = RETRY_W'(5);
  localparam logic [WAIT_W-1:0]  WAIT_MAX    = '1;

  typedef enum logic {
    REG_DELAY = 1'b0,
    REG_RETRY = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    MAIN_PULSE_HI = 3'd0,
    MAIN_PULSE_LO = 3'd1,
    MAIN_CHECK    = 3'd2,
    MAIN_WRITE    = 3'd3,
    MAIN_SEARCH   = 3'd4,
    MAIN_LOCKED   = 3'd5
  } main_phase_t;

  typedef enum logic [1:0] {
    SRCH_PULSE_HI = 2'd0,
    SRCH_PULSE_LO = 2'd1,
    SRCH_CHECK    = 2'd2,
    SRCH_TEST     = 2'd3
  } search_phase_t;

  typedef enum logic [1:0] {
    ORG_PULSE_HI = 2'd0,
    ORG_PULSE_LO = 2'd1,
    ORG_CHECK    = 2'd2,
    ORG_WRITE    = 2'd3
  } origin_t;

  typedef struct packed {
    logic switch_down;
    logic switch_up;
    logic fault_line;
  } item_t;

  typedef struct packed {
    main_phase_t seq_state;
    logic        searching;
    logic        lockout;
    logic [7:0]  error_mask;
    logic [7:0]  drive_err_mask;
    logic [7:0]  drive_mask;
    logic        restart_level;
  } res_t;

endpackage

// File: rtl/ofis_core.sv
// Sequencer state and per-tick step logic of the output fault isolation sequencer.
// Depends on ofis_pkg and output_fault_isolation_sequencer_defines.svh.
`include "output_fault_isolation_sequencer_defines.svh"

module ofis_core #(
  parameter int NUM_CHANNELS = ofis_pkg::NUM_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  ofis_pkg::item_t               item,
  input  logic [ofis_pkg::DELAY_W-1:0]  delay_ticks,
  input  logic [ofis_pkg::RETRY_W-1:0]  retry_limit,
  output ofis_pkg::res_t                result
);
  import ofis_pkg::*;

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int MW = (NUM_CHANNELS > 8) ? NUM_CHANNELS : 8;
  localparam logic [CW-1:0]           LAST_CH = CW'(NUM_CHANNELS - 1);
  localparam logic [NUM_CHANNELS-1:0] CH_ALL  = '1;

  logic [WAIT_W-1:0]       wait_count, wait_next;
  main_phase_t             main_phase, main_phase_next;
  origin_t                 main_origin, main_origin_next;
  logic [RETRY_W-1:0]      main_retries, main_retries_next;
  search_phase_t           search_phase, search_phase_next;
  origin_t                 search_origin, search_origin_next;
  logic [RETRY_W-1:0]      search_retries, search_retries_next;
  logic [CW-1:0]           channel_index, channel_index_next;
  logic                    lockout_flag, lockout_flag_next;
  logic                    search_flag, search_flag_next;
  logic                    restart_out, restart_out_next;
  logic [NUM_CHANNELS-1:0] command_mask, command_mask_next;
  logic [NUM_CHANNELS-1:0] fault_marks, fault_marks_next;
  logic [NUM_CHANNELS-1:0] latched_drive, latched_drive_next;
  logic [NUM_CHANNELS-1:0] latched_err, latched_err_next;

  logic [NUM_CHANNELS-1:0] ch_bit;
  logic [WAIT_W-1:0]       delay_wait;
  logic [LONG_W-1:0]       long_prod;
  logic [WAIT_W-1:0]       long_wait;
  logic                    tripped;

  function automatic logic [7:0] to_byte(input logic [NUM_CHANNELS-1:0] m);
    logic [MW-1:0] w;
    w = MW'(m);
    return w[7:0];
  endfunction

  assign tripped    = ~item.fault_line;
  assign ch_bit     = NUM_CHANNELS'(1) << channel_index;
  assign delay_wait = WAIT_W'(delay_ticks);
  assign long_prod  = LONG_W'(delay_ticks) * LONG_W'(LONG_FACTOR);
  assign long_wait  = (long_prod > LONG_W'(WAIT_MAX)) ? WAIT_MAX : long_prod[WAIT_W-1:0];

  always_comb begin
    wait_next           = wait_count;
    main_phase_next     = main_phase;
    main_origin_next    = main_origin;
    main_retries_next   = main_retries;
    search_phase_next   = search_phase;
    search_origin_next  = search_origin;
    search_retries_next = search_retries;
    channel_index_next  = channel_index;
    lockout_flag_next   = lockout_flag;
    search_flag_next    = search_flag;
    restart_out_next    = restart_out;
    command_mask_next   = command_mask;
    fault_marks_next    = fault_marks;
    latched_drive_next  = latched_drive;
    latched_err_next    = latched_err;

    if (wait_next != '0) begin
      wait_next = wait_next - WAIT_W'(1);
    end

    if (wait_next == '0) begin
      case (main_phase)
        MAIN_PULSE_HI: begin
          restart_out_next = 1'b1;
          main_phase_next  = MAIN_PULSE_LO;
          main_origin_next = ORG_PULSE_HI;
          wait_next        = delay_wait;
        end
        MAIN_PULSE_LO: begin
          restart_out_next = 1'b0;
          wait_next        = delay_wait;
          main_phase_next  = MAIN_CHECK;
          main_origin_next = ORG_PULSE_LO;
        end
        MAIN_CHECK: begin
          if (tripped && main_origin == ORG_PULSE_LO) begin
            main_phase_next   = MAIN_PULSE_HI;
            main_retries_next = main_retries + RETRY_W'(1);
            if (main_retries_next >= retry_limit) begin
              main_retries_next = '0;
              lockout_flag_next = 1'b1;
              main_phase_next   = MAIN_LOCKED;
            end
            wait_next = delay_wait;
          end else if (tripped && main_origin == ORG_WRITE) begin
            search_flag_next    = 1'b1;
            main_phase_next     = MAIN_SEARCH;
            search_phase_next   = SRCH_PULSE_HI;
            channel_index_next  = '0;
            search_retries_next = '0;
            latched_drive_next  = '0;
            latched_err_next    = fault_marks;
            wait_next           = delay_wait;
          end else begin
            main_phase_next = MAIN_WRITE;
          end
        end
        MAIN_WRITE: begin
          latched_drive_next = command_mask;
          latched_err_next   = fault_marks;
          main_phase_next    = MAIN_CHECK;
          main_origin_next   = ORG_WRITE;
        end
        MAIN_SEARCH: begin
          case (search_phase)
            SRCH_PULSE_HI: begin
              restart_out_next   = 1'b1;
              search_phase_next  = SRCH_PULSE_LO;
              search_origin_next = ORG_PULSE_HI;
              wait_next          = delay_wait;
            end
            SRCH_PULSE_LO: begin
              restart_out_next   = 1'b0;
              wait_next          = delay_wait;
              search_phase_next  = SRCH_CHECK;
              search_origin_next = ORG_PULSE_LO;
            end
            SRCH_CHECK: begin
              if (tripped && search_origin == ORG_PULSE_LO) begin
                search_phase_next   = SRCH_PULSE_HI;
                search_retries_next = search_retries + RETRY_W'(1);
                wait_next           = delay_wait;
                if (search_retries_next >= retry_limit) begin
                  search_retries_next = '0;
                  lockout_flag_next   = 1'b1;
                  main_phase_next     = MAIN_LOCKED;
                end
              end else if (tripped && search_origin == ORG_WRITE) begin
                fault_marks_next   = fault_marks | ch_bit;
                command_mask_next  = command_mask & ~ch_bit;
                latched_drive_next = '0;
                latched_err_next   = fault_marks_next;
                wait_next          = delay_wait;
                search_phase_next  = SRCH_PULSE_HI;
              end else begin
                search_phase_next = SRCH_TEST;
              end
              if (search_origin == ORG_WRITE) begin
                if (channel_index >= LAST_CH) begin
                  search_phase_next = SRCH_PULSE_HI;
                  main_retries_next = '0;
                  main_phase_next   = MAIN_PULSE_HI;
                  wait_next         = delay_wait;
                end else begin
                  channel_index_next = channel_index + CW'(1);
                end
              end
              search_origin_next = ORG_CHECK;
            end
            SRCH_TEST: begin
              latched_drive_next = command_mask & ch_bit;
              latched_err_next   = fault_marks;
              search_phase_next  = SRCH_CHECK;
              search_origin_next = ORG_WRITE;
              wait_next          = long_wait;
            end
            default: begin
            end
          endcase
        end
        MAIN_LOCKED: begin
          latched_drive_next = '0;
          latched_err_next   = fault_marks;
          fault_marks_next   = CH_ALL;
          if (!lockout_flag) begin
            main_phase_next   = MAIN_PULSE_HI;
            search_phase_next = SRCH_PULSE_HI;
            main_retries_next = '0;
          end
        end
        default: begin
        end
      endcase
    end

    // switch: up wins over down
    if (item.switch_up) begin
      command_mask_next = CH_ALL;
    end else if (item.switch_down) begin
      fault_marks_next  = '0;
      lockout_flag_next = 1'b0;
    end else begin
      command_mask_next = '0;
    end

    result.restart_level  = restart_out_next;
    result.drive_mask     = to_byte(latched_drive_next);
    result.drive_err_mask = to_byte(latched_err_next);
    result.error_mask     = to_byte(fault_marks_next);
    result.lockout        = lockout_flag_next;
    result.searching      = search_flag_next;
    result.seq_state      = main_phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_count     <= '0;
      main_phase     <= MAIN_PULSE_HI;
      main_origin    <= ORG_PULSE_HI;
      main_retries   <= '0;
      search_phase   <= SRCH_PULSE_HI;
      search_origin  <= ORG_PULSE_HI;
      search_retries <= '0;
      channel_index  <= '0;
      lockout_flag   <= 1'b0;
      search_flag    <= 1'b0;
      restart_out    <= 1'b0;
      command_mask   <= '0;
      fault_marks    <= '0;
      latched_drive  <= '0;
      latched_err    <= '0;
    end else if (advance) begin
      wait_count     <= wait_next;
      main_phase     <= main_phase_next;
      main_origin    <= main_origin_next;
      main_retries   <= main_retries_next;
      search_phase   <= search_phase_next;
      search_origin  <= search_origin_next;
      search_retries <= search_retries_next;
      channel_index  <= channel_index_next;
      lockout_flag   <= lockout_flag_next;
      search_flag    <= search_flag_next;
      restart_out    <= restart_out_next;
      command_mask   <= command_mask_next;
      fault_marks    <= fault_marks_next;
      latched_drive  <= latched_drive_next;
      latched_err    <= latched_err_next;
    end
  end

  `OFIS_ASSERT_ALWAYS(a_lockout_in_locked, lockout_flag |-> main_phase == MAIN_LOCKED, "lockout outside locked phase")
  `OFIS_ASSERT(a_search_flagged, main_phase == MAIN_SEARCH |-> search_flag, "search phase without search flag")
  `OFIS_ASSERT(a_restart_rise, $rose(restart_out) |-> main_phase == MAIN_PULSE_LO || (main_phase == MAIN_SEARCH && search_phase == SRCH_PULSE_LO), "restart rose outside a pulse")
  `OFIS_ASSERT(a_hold_idle, !advance |=> $stable(main_phase) && $stable(wait_count), "state moved without a transfer")

endmodule

// File: rtl/output_fault_isolation_sequencer.sv
// Top level of the output fault isolation sequencer: stream ports, APB registers, result register.
// Depends on ofis_pkg and ofis_core.
//
//   port group   dir   fields
//   s_*          in    tick: fault_line, switch_up, switch_down
//   m_*          out   status: restart_level .. seq_state, one per tick
//   APB          in    delay_ticks @0x0, retry_limit @0x4
//
// One tick per cycle while m drains; an accepted tick lands in the input register, the step logic
// runs combinationally on it and its status lands in the output register when the tick advances.
// From an s transfer the tick passes the input register, then the output register, to m_tvalid.
// rst clears the sequence state and loads delay_ticks 100 and retry_limit 5.
// A stalled m side holds its status and the input register, then s_tready drops.
module output_fault_isolation_sequencer #(
  parameter int NUM_CHANNELS = ofis_pkg::NUM_CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ofis_pkg::IN_W-1:0]    s_tdata,   // [0] fault_line, [1] switch_up, [2] switch_down
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ofis_pkg::OUT_W-1:0]   m_tdata,   // [0] restart_level, [8:1] drive_mask,
                                                  // [16:9] drive_err_mask, [24:17] error_mask,
                                                  // [25] lockout, [26] searching, [29:27] seq_state
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ofis_pkg::ADDR_W-1:0]  paddr,
  input  logic [ofis_pkg::DATA_W-1:0]  pwdata,
  output logic [ofis_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import ofis_pkg::*;

  logic [DELAY_W-1:0] delay_ticks;
  logic [RETRY_W-1:0] retry_limit;
  logic               in_valid;
  item_t              in_item;
  logic               out_valid;
  res_t               out_res;
  res_t               result;
  logic               advance;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_RETRY) ? DATA_W'(retry_limit) : DATA_W'(delay_ticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= DELAY_RESET;
      retry_limit <= RETRY_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_RETRY) begin
        retry_limit <= pwdata[RETRY_W-1:0];
      end else begin
        delay_ticks <= pwdata[DELAY_W-1:0];
      end
    end
  end

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'(out_res);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_tdata[$bits(item_t)-1:0];
    end
    if (advance) begin
      out_res <= result;
    end
  end

  ofis_core #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (in_item),
    .delay_ticks (delay_ticks),
    .retry_limit (retry_limit),
    .result      (result)
  );

endmodule
